/* design/urtb_pkg.sv */
package urtb_pkg;

    typedef enum logic [2:0]
    {
        REQ_RX_BYTE   = 3'd0,
        REQ_HOST_READ = 3'd1,
        REQ_TX_BYTE   = 3'd2,
        REQ_TX_READY  = 3'd3,
        REQ_OVF_QUERY = 3'd4
    } urtb_req_t;

    localparam int unsigned ReqWidth  = 3;
    localparam int unsigned ByteWidth = 8;

    typedef struct packed
    {
        logic accept;
    } urtb_cmd_t;

endpackage

/* design/urtb_ram.sv */
module urtb_ram
#(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 128
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/urtb_ctrl.sv */
module urtb_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    output urtb_pkg::urtb_cmd_t cmd
);

    import urtb_pkg::*;

    typedef enum logic
    {
        ST_IDLE,
        ST_RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // A new beat may enter in the same cycle as the pending result leaves.
    assign in_stall  = (state_reg == ST_RESULT) && out_stall;
    assign accept    = in_valid && !in_stall;
    assign out_valid = (state_reg == ST_RESULT);
    assign cmd.accept = accept;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (!out_stall && !accept)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* design/urtb_dp.sv */
module urtb_dp
#(
    parameter int unsigned RX_DEPTH = 128,
    parameter int unsigned TX_DEPTH = 128
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  urtb_pkg::urtb_cmd_t cmd,
    input  logic [2:0]          req_type,
    input  logic [7:0]          rx_data,
    input  logic                rx_error,
    input  logic [7:0]          tx_data,
    input  logic                tx_first,
    input  logic [7:0]          tx_batch_len,
    output logic [7:0]          read_data,
    output logic                tx_accepted,
    output logic                send_valid,
    output logic [7:0]          send_data,
    output logic                tx_irq_enable,
    output logic [7:0]          rx_count,
    output logic                rx_empty,
    output logic                overflow_flag
);

    import urtb_pkg::*;

    localparam int unsigned RxIdxW  = $clog2(RX_DEPTH);
    localparam int unsigned TxIdxW  = $clog2(TX_DEPTH);
    localparam int unsigned RxFillW = $clog2(RX_DEPTH + 1);
    localparam int unsigned TxFillW = $clog2(TX_DEPTH + 1);
    localparam int unsigned SumW    = ((TxFillW > ByteWidth) ? TxFillW : ByteWidth) + 1;

    logic [RxIdxW-1:0]  rx_wr_idx_reg, rx_wr_idx_next;
    logic [RxIdxW-1:0]  rx_rd_idx_reg, rx_rd_idx_next;
    logic [RxFillW-1:0] rx_fill_reg, rx_fill_next;
    logic [TxIdxW-1:0]  tx_wr_idx_reg, tx_wr_idx_next;
    logic [TxIdxW-1:0]  tx_rd_idx_reg, tx_rd_idx_next;
    logic [TxFillW-1:0] tx_fill_reg, tx_fill_next;
    logic               ovf_sticky_reg, ovf_sticky_next;
    logic               tx_irq_on_reg, tx_irq_on_next;
    logic               batch_adm_reg, batch_adm_next;

    logic               rx_pop_reg, rx_pop_next;
    logic               tx_acc_reg, tx_acc_next;
    logic               tx_pop_reg, tx_pop_next;
    logic               ovf_out_reg, ovf_out_next;

    logic               rx_we, rx_re, tx_we, tx_re;
    logic [7:0]         rx_rdata, tx_rdata;
    logic [SumW-1:0]    batch_sum;
    logic [RxFillW+7:0] rx_fill_ext;
    urtb_req_t          req;

    assign req = urtb_req_t'(req_type);
    assign batch_sum = SumW'(tx_batch_len) + SumW'(tx_fill_reg);

    always_comb
    begin
        rx_wr_idx_next  = rx_wr_idx_reg;
        rx_rd_idx_next  = rx_rd_idx_reg;
        rx_fill_next    = rx_fill_reg;
        tx_wr_idx_next  = tx_wr_idx_reg;
        tx_rd_idx_next  = tx_rd_idx_reg;
        tx_fill_next    = tx_fill_reg;
        ovf_sticky_next = ovf_sticky_reg;
        tx_irq_on_next  = tx_irq_on_reg;
        batch_adm_next  = batch_adm_reg;
        rx_pop_next     = 1'b0;
        tx_acc_next     = 1'b0;
        tx_pop_next     = 1'b0;
        rx_we           = 1'b0;
        rx_re           = 1'b0;
        tx_we           = 1'b0;
        tx_re           = 1'b0;

        unique case (req)
            REQ_RX_BYTE:
            begin
                if (!rx_error)
                begin
                    if (rx_fill_reg < RxFillW'(RX_DEPTH))
                    begin
                        rx_we = 1'b1;
                        rx_wr_idx_next = (rx_wr_idx_reg == RxIdxW'(RX_DEPTH - 1)) ?
                                         '0 : rx_wr_idx_reg + 1'b1;
                        rx_fill_next = rx_fill_reg + 1'b1;
                        if (rx_fill_reg == RxFillW'(RX_DEPTH - 1))
                        begin
                            ovf_sticky_next = 1'b1;
                        end
                    end
                    else
                    begin
                        ovf_sticky_next = 1'b1;
                    end
                end
            end
            REQ_HOST_READ:
            begin
                if (rx_fill_reg != '0)
                begin
                    rx_re = 1'b1;
                    rx_pop_next = 1'b1;
                    rx_rd_idx_next = (rx_rd_idx_reg == RxIdxW'(RX_DEPTH - 1)) ?
                                     '0 : rx_rd_idx_reg + 1'b1;
                    rx_fill_next = rx_fill_reg - 1'b1;
                end
            end
            REQ_TX_BYTE:
            begin
                if (tx_first)
                begin
                    batch_adm_next = (batch_sum <= SumW'(TX_DEPTH));
                end
                if (batch_adm_next && (tx_fill_reg < TxFillW'(TX_DEPTH)))
                begin
                    tx_we = 1'b1;
                    tx_wr_idx_next = (tx_wr_idx_reg == TxIdxW'(TX_DEPTH - 1)) ?
                                     '0 : tx_wr_idx_reg + 1'b1;
                    tx_fill_next = tx_fill_reg + 1'b1;
                    tx_irq_on_next = 1'b1;
                end
                tx_acc_next = batch_adm_next;
            end
            REQ_TX_READY:
            begin
                if (tx_fill_reg != '0)
                begin
                    tx_re = 1'b1;
                    tx_pop_next = 1'b1;
                    tx_rd_idx_next = (tx_rd_idx_reg == TxIdxW'(TX_DEPTH - 1)) ?
                                     '0 : tx_rd_idx_reg + 1'b1;
                    tx_fill_next = tx_fill_reg - 1'b1;
                end
                else
                begin
                    tx_irq_on_next = 1'b0;
                end
            end
            default:
            begin
            end
        endcase

        ovf_out_next = ovf_sticky_next;
        if (req == REQ_OVF_QUERY)
        begin
            ovf_sticky_next = 1'b0;
        end

        if (!cmd.accept)
        begin
            rx_we = 1'b0;
            rx_re = 1'b0;
            tx_we = 1'b0;
            tx_re = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_wr_idx_reg  <= '0;
            rx_rd_idx_reg  <= '0;
            rx_fill_reg    <= '0;
            tx_wr_idx_reg  <= '0;
            tx_rd_idx_reg  <= '0;
            tx_fill_reg    <= '0;
            ovf_sticky_reg <= 1'b0;
            tx_irq_on_reg  <= 1'b0;
            batch_adm_reg  <= 1'b0;
            rx_pop_reg     <= 1'b0;
            tx_acc_reg     <= 1'b0;
            tx_pop_reg     <= 1'b0;
            ovf_out_reg    <= 1'b0;
        end
        else if (cmd.accept)
        begin
            rx_wr_idx_reg  <= rx_wr_idx_next;
            rx_rd_idx_reg  <= rx_rd_idx_next;
            rx_fill_reg    <= rx_fill_next;
            tx_wr_idx_reg  <= tx_wr_idx_next;
            tx_rd_idx_reg  <= tx_rd_idx_next;
            tx_fill_reg    <= tx_fill_next;
            ovf_sticky_reg <= ovf_sticky_next;
            tx_irq_on_reg  <= tx_irq_on_next;
            batch_adm_reg  <= batch_adm_next;
            rx_pop_reg     <= rx_pop_next;
            tx_acc_reg     <= tx_acc_next;
            tx_pop_reg     <= tx_pop_next;
            ovf_out_reg    <= ovf_out_next;
        end
    end

    urtb_ram
    #(
        .WIDTH (ByteWidth),
        .DEPTH (RX_DEPTH)
    )
    u_rx_ram
    (
        .clk   (clk),
        .we    (rx_we),
        .waddr (rx_wr_idx_reg),
        .wdata (rx_data),
        .re    (rx_re),
        .raddr (rx_rd_idx_reg),
        .rdata (rx_rdata)
    );

    urtb_ram
    #(
        .WIDTH (ByteWidth),
        .DEPTH (TX_DEPTH)
    )
    u_tx_ram
    (
        .clk   (clk),
        .we    (tx_we),
        .waddr (tx_wr_idx_reg),
        .wdata (tx_data),
        .re    (tx_re),
        .raddr (tx_rd_idx_reg),
        .rdata (tx_rdata)
    );

    // The state registers change only when a beat is accepted, so they hold the result.
    assign rx_fill_ext   = {8'd0, rx_fill_reg};
    assign read_data     = rx_pop_reg ? rx_rdata : 8'd0;
    assign tx_accepted   = tx_acc_reg;
    assign send_valid    = tx_pop_reg;
    assign send_data     = tx_pop_reg ? tx_rdata : 8'd0;
    assign tx_irq_enable = tx_irq_on_reg;
    assign rx_count      = rx_fill_ext[7:0];
    assign rx_empty      = (rx_fill_reg == '0);
    assign overflow_flag = ovf_out_reg;

endmodule

/* design/uart_rx_tx_ring_buffers.sv */
// Receive and transmit ring buffers of a serial port, driven by one event per input beat
// and answering each with exactly one result beat. The result appears in the cycle after
// the event is accepted, once the buffer memory's registered read has returned the
// popped byte; a new event is taken in the same cycle as the previous result leaves, so
// with no stall on the output the block handles one event per cycle. Buffer entries hold
// no reset value, and the fill counts, indices and flags are cleared by reset.
module uart_rx_tx_ring_buffers
#(
    parameter int unsigned RX_DEPTH = 128,
    parameter int unsigned TX_DEPTH = 128
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] req_type,
    input  logic [7:0] rx_data,
    input  logic       rx_error,
    input  logic [7:0] tx_data,
    input  logic       tx_first,
    input  logic [7:0] tx_batch_len,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] read_data,
    output logic       tx_accepted,
    output logic       send_valid,
    output logic [7:0] send_data,
    output logic       tx_irq_enable,
    output logic [7:0] rx_count,
    output logic       rx_empty,
    output logic       overflow_flag
);

    import urtb_pkg::*;

    urtb_cmd_t cmd;

    urtb_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    urtb_dp
    #(
        .RX_DEPTH (RX_DEPTH),
        .TX_DEPTH (TX_DEPTH)
    )
    u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .req_type      (req_type),
        .rx_data       (rx_data),
        .rx_error      (rx_error),
        .tx_data       (tx_data),
        .tx_first      (tx_first),
        .tx_batch_len  (tx_batch_len),
        .read_data     (read_data),
        .tx_accepted   (tx_accepted),
        .send_valid    (send_valid),
        .send_data     (send_data),
        .tx_irq_enable (tx_irq_enable),
        .rx_count      (rx_count),
        .rx_empty      (rx_empty),
        .overflow_flag (overflow_flag)
    );

endmodule

/* design/urtb_chk.sv */
module urtb_chk
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [2:0] req_type,
    input logic       out_valid,
    input logic       out_stall,
    input logic       tx_accepted,
    input logic       send_valid,
    input logic       tx_irq_enable
);

    import urtb_pkg::*;

    // A stalled result beat stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result beat withdrawn while stalled");

    // Every accepted event yields a result in the next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("accepted event gave no result");

    // Only a host transmit byte can report an admitted batch.
    a_accept_only_tx: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (req_type != REQ_TX_BYTE) |=> !tx_accepted)
        else $error("tx_accepted set for an event other than a transmit byte");

    // A byte can only be sent after a stored byte has enabled the interrupt.
    a_send_irq: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && send_valid |-> tx_irq_enable)
        else $error("byte sent with the transmit interrupt disabled");

endmodule

bind uart_rx_tx_ring_buffers urtb_chk u_chk (.*);

/* dv/urtb_ring_checker.sv */
`timescale 1ns / 1ps

module urtb_ring_checker
    import urtb_pkg::*;
#(
    parameter int unsigned RX_DEPTH = 128,
    parameter int unsigned TX_DEPTH = 128
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [2:0]  req_type,
    input  logic [7:0]  rx_data,
    input  logic        rx_error,
    input  logic [7:0]  tx_data,
    input  logic        tx_first,
    input  logic [7:0]  tx_batch_len,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [7:0]  read_data,
    input  logic        tx_accepted,
    input  logic        send_valid,
    input  logic [7:0]  send_data,
    input  logic        tx_irq_enable,
    input  logic [7:0]  rx_count,
    input  logic        rx_empty,
    input  logic        overflow_flag,
    output int unsigned mismatches,
    output int unsigned pending,
    output int unsigned checked
);

    typedef struct packed
    {
        logic [7:0] read_data;
        logic       accepted;
        logic       send_valid;
        logic [7:0] send_data;
        logic       irq;
        logic [7:0] rx_count;
        logic       rx_empty;
        logic       ovf;
    } port_status_t;

    logic [7:0]   rx_ring [RX_DEPTH];
    logic [7:0]   tx_ring [TX_DEPTH];
    int unsigned  rx_head;
    int unsigned  rx_tail;
    int unsigned  rx_fill;
    int unsigned  tx_head;
    int unsigned  tx_tail;
    int unsigned  tx_fill;
    logic         ovf_sticky;
    logic         irq_on;
    logic         batch_ok;
    port_status_t status_due [$];
    port_status_t seen;
    port_status_t due;
    logic         bad;

    function automatic string fmt_status(input port_status_t s);
        return $sformatf("rd=%02h acc=%b snd=%b/%02h irq=%b cnt=%0d emp=%b ovf=%b",
                         s.read_data, s.accepted, s.send_valid, s.send_data, s.irq,
                         s.rx_count, s.rx_empty, s.ovf);
    endfunction

    function automatic port_status_t advance_rings(
        input logic [2:0] req,
        input logic [7:0] rxd,
        input logic       rxerr,
        input logic [7:0] txd,
        input logic       first,
        input logic [7:0] blen
    );
        port_status_t s;
        s = '0;
        case (req)
            REQ_RX_BYTE:
            begin
                if (!rxerr)
                begin
                    if (rx_fill < RX_DEPTH)
                    begin
                        rx_ring[rx_tail] = rxd;
                        rx_tail = (rx_tail + 1 == RX_DEPTH) ? 0 : rx_tail + 1;
                        rx_fill++;
                        if (rx_fill == RX_DEPTH)
                            ovf_sticky = 1'b1;
                    end
                    else
                        ovf_sticky = 1'b1;
                end
            end
            REQ_HOST_READ:
            begin
                if (rx_fill != 0)
                begin
                    s.read_data = rx_ring[rx_head];
                    rx_head = (rx_head + 1 == RX_DEPTH) ? 0 : rx_head + 1;
                    rx_fill--;
                end
            end
            REQ_TX_BYTE:
            begin
                if (first)
                    batch_ok = (int'(blen) + tx_fill) <= TX_DEPTH;
                if (batch_ok && tx_fill < TX_DEPTH)
                begin
                    tx_ring[tx_tail] = txd;
                    tx_tail = (tx_tail + 1 == TX_DEPTH) ? 0 : tx_tail + 1;
                    tx_fill++;
                    irq_on = 1'b1;
                end
                s.accepted = batch_ok;
            end
            REQ_TX_READY:
            begin
                if (tx_fill != 0)
                begin
                    s.send_valid = 1'b1;
                    s.send_data = tx_ring[tx_head];
                    tx_head = (tx_head + 1 == TX_DEPTH) ? 0 : tx_head + 1;
                    tx_fill--;
                end
                else
                    irq_on = 1'b0;
            end
            default:
            begin
            end
        endcase
        s.irq = irq_on;
        s.rx_count = 8'(rx_fill);
        s.rx_empty = (rx_fill == 0);
        s.ovf = ovf_sticky;
        if (req == REQ_OVF_QUERY)
            ovf_sticky = 1'b0;
        return s;
    endfunction

    // A result beat can never belong to an event accepted at the same edge, so the
    // output side is checked before the input side is predicted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_head = 0;
            rx_tail = 0;
            rx_fill = 0;
            tx_head = 0;
            tx_tail = 0;
            tx_fill = 0;
            ovf_sticky = 1'b0;
            irq_on = 1'b0;
            batch_ok = 1'b0;
            status_due.delete();
            mismatches <= 0;
            pending <= 0;
            checked <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                seen = '{read_data: read_data, accepted: tx_accepted, send_valid: send_valid,
                         send_data: send_data, irq: tx_irq_enable, rx_count: rx_count,
                         rx_empty: rx_empty, ovf: overflow_flag};
                bad = 1'b0;
                if (status_due.size() == 0)
                begin
                    bad = 1'b1;
                    if (mismatches < 10)
                        $display("Unexpected result beat: %s", fmt_status(seen));
                end
                else
                begin
                    due = status_due.pop_front();
                    if (seen !== due)
                    begin
                        bad = 1'b1;
                        if (mismatches < 10)
                            $display("Result beat %0d: expected %s, got %s", checked,
                                     fmt_status(due), fmt_status(seen));
                    end
                end
                if (bad)
                    mismatches <= mismatches + 1;
                checked <= checked + 1;
            end
            if (in_valid && !in_stall)
                status_due.push_back(advance_rings(req_type, rx_data, rx_error, tx_data,
                                                   tx_first, tx_batch_len));
            pending <= status_due.size();
        end
    end

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;
    import urtb_pkg::*;

    localparam int unsigned RxDepth     = 128;
    localparam int unsigned TxDepth     = 128;
    localparam int unsigned CycleLimit  = 400000;
    localparam int unsigned HoldCycles  = 300;
    localparam int unsigned PhaseEvents = 330;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  req_type;
    logic [7:0]  rx_data;
    logic        rx_error;
    logic [7:0]  tx_data;
    logic        tx_first;
    logic [7:0]  tx_batch_len;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  read_data;
    logic        tx_accepted;
    logic        send_valid;
    logic [7:0]  send_data;
    logic        tx_irq_enable;
    logic [7:0]  rx_count;
    logic        rx_empty;
    logic        overflow_flag;

    int unsigned mismatches;
    int unsigned pending;
    int unsigned checked;
    int unsigned stall_pct = 0;
    int unsigned gap_pct = 0;
    logic        hold_req;
    int unsigned events_sent = 0;
    int unsigned kind_count [8];
    int unsigned cycles;

    uart_rx_tx_ring_buffers #(.RX_DEPTH(RxDepth), .TX_DEPTH(TxDepth)) uut
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .req_type(req_type), .rx_data(rx_data), .rx_error(rx_error),
        .tx_data(tx_data), .tx_first(tx_first), .tx_batch_len(tx_batch_len),
        .out_valid(out_valid), .out_stall(out_stall),
        .read_data(read_data), .tx_accepted(tx_accepted), .send_valid(send_valid),
        .send_data(send_data), .tx_irq_enable(tx_irq_enable), .rx_count(rx_count),
        .rx_empty(rx_empty), .overflow_flag(overflow_flag)
    );

    urtb_ring_checker #(.RX_DEPTH(RxDepth), .TX_DEPTH(TxDepth)) ring_check
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .req_type(req_type), .rx_data(rx_data), .rx_error(rx_error),
        .tx_data(tx_data), .tx_first(tx_first), .tx_batch_len(tx_batch_len),
        .out_valid(out_valid), .out_stall(out_stall),
        .read_data(read_data), .tx_accepted(tx_accepted), .send_valid(send_valid),
        .send_data(send_data), .tx_irq_enable(tx_irq_enable), .rx_count(rx_count),
        .rx_empty(rx_empty), .overflow_flag(overflow_flag),
        .mismatches(mismatches), .pending(pending), .checked(checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles <= CycleLimit)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        logic hold_done;
        hold_done = 1'b0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                out_stall <= 1'b1;
                repeat (HoldCycles) @(posedge clk);
                hold_done = 1'b1;
            end
            else
                out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
        end
    end

    task automatic send_event(input logic [2:0] req, input logic [7:0] rxd, input logic rxerr,
                              input logic [7:0] txd, input logic first, input logic [7:0] blen);
        if (gap_pct != 0 && $urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= req;
        rx_data <= rxd;
        rx_error <= rxerr;
        tx_data <= txd;
        tx_first <= first;
        tx_batch_len <= blen;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        events_sent++;
        kind_count[req]++;
    endtask

    task automatic send_any(input logic [2:0] req, input logic rxerr);
        send_event(req, 8'($urandom), rxerr, 8'($urandom), 1'($urandom_range(1)),
                   8'($urandom));
    endtask

    task automatic send_batch(input logic [7:0] blen, input int unsigned nbytes);
        send_event(REQ_TX_BYTE, 8'($urandom), 1'($urandom_range(1)), 8'($urandom), 1'b1, blen);
        for (int i = 1; i < nbytes; i++)
            send_event(REQ_TX_BYTE, 8'($urandom), 1'($urandom_range(1)), 8'($urandom), 1'b0,
                       8'($urandom));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    task automatic random_event(input logic rx_lean, input logic tx_lean);
        int unsigned pick;
        int unsigned rx_w;
        int unsigned bt_w;
        int unsigned rdy_w;
        int unsigned blen;
        int unsigned nbytes;
        rx_w = rx_lean ? 40 : 18;
        bt_w = tx_lean ? 14 : 5;
        rdy_w = tx_lean ? 12 : 30;
        pick = $urandom_range(99);
        if (pick < 4)
            send_any(3'($urandom_range(7)), 1'($urandom_range(1)));
        else if (pick < 10)
            send_any(REQ_OVF_QUERY, 1'($urandom_range(1)));
        else if (pick < 10 + rx_w)
            send_any(REQ_RX_BYTE, $urandom_range(9) == 0);
        else if (pick < 10 + rx_w + bt_w)
        begin
            pick = $urandom_range(99);
            if (pick < 80)
                blen = $urandom_range(1, 10);
            else if (pick < 92)
                blen = $urandom_range(11, 60);
            else
                blen = $urandom_range(255);
            nbytes = (blen == 0) ? 1 : ((blen > 40) ? 40 : blen);
            if ($urandom_range(9) == 0)
                nbytes = $urandom_range(1, nbytes + 3);
            send_batch(8'(blen), nbytes);
        end
        else if (pick < 10 + rx_w + bt_w + rdy_w)
            send_any(REQ_TX_READY, 1'($urandom_range(1)));
        else
            send_any(REQ_HOST_READ, 1'($urandom_range(1)));
    endtask

    task automatic run_phase(input int unsigned gap, input int unsigned stall,
                             input int unsigned count);
        int unsigned stop_at;
        logic        rx_lean;
        logic        tx_lean;
        gap_pct = gap;
        stall_pct <= stall;
        rx_lean = 1'($urandom_range(1));
        tx_lean = 1'($urandom_range(1));
        stop_at = events_sent + count;
        while (events_sent < stop_at)
        begin
            if ($urandom_range(59) == 0)
            begin
                rx_lean = 1'($urandom_range(1));
                tx_lean = 1'($urandom_range(1));
            end
            random_event(rx_lean, tx_lean);
        end
        drain();
    endtask

    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        req_type <= REQ_RX_BYTE;
        rx_data <= '0;
        rx_error <= 1'b0;
        tx_data <= '0;
        tx_first <= 1'b0;
        tx_batch_len <= '0;
        hold_req <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_any(REQ_HOST_READ, 1'b0);
        send_any(REQ_TX_READY, 1'b0);
        send_any(REQ_OVF_QUERY, 1'b0);
        send_event(REQ_RX_BYTE, 8'h00, 1'b0, 8'hFF, 1'b1, 8'hFF);
        send_event(REQ_RX_BYTE, 8'hFF, 1'b0, 8'h00, 1'b0, 8'h00);
        send_event(REQ_RX_BYTE, 8'hA5, 1'b1, 8'h5A, 1'b1, 8'h80);
        repeat (3) send_any(REQ_HOST_READ, 1'b1);
        send_event(REQ_TX_BYTE, 8'h00, 1'b1, 8'hFF, 1'b1, 8'h00);
        send_event(REQ_TX_BYTE, 8'hFF, 1'b0, 8'h11, 1'b1, 8'hFF);
        send_event(REQ_TX_BYTE, 8'h00, 1'b0, 8'h22, 1'b0, 8'h00);
        send_event(REQ_TX_BYTE, 8'h5A, 1'b1, 8'h00, 1'b1, 8'h02);
        send_event(REQ_TX_BYTE, 8'hA5, 1'b0, 8'h80, 1'b0, 8'h7F);
        repeat (4) send_any(REQ_TX_READY, 1'b0);
        for (int code = REQ_OVF_QUERY + 1; code < 8; code++)
            send_any(3'(code), 1'b1);
        send_any(REQ_OVF_QUERY, 1'b0);
        drain();

        // Both rings are taken to full and back to empty, including the dropped byte
        // of a batch that was admitted into a full ring.
        send_batch(8'(TxDepth), TxDepth);
        send_event(REQ_TX_BYTE, 8'($urandom), 1'b0, 8'($urandom), 1'b1, 8'h00);
        send_batch(8'h01, 1);
        repeat (TxDepth + 1) send_any(REQ_TX_READY, 1'b0);
        repeat (RxDepth + 1) send_any(REQ_RX_BYTE, 1'b0);
        repeat (2) send_any(REQ_OVF_QUERY, 1'b0);
        repeat (RxDepth + 1) send_any(REQ_HOST_READ, 1'b0);
        drain();

        // Long receiver hold-off so that the block fills and stalls its input beats.
        hold_req <= 1'b1;
        repeat (60) random_event(1'b1, 1'b1);
        drain();

        run_phase(0, 0, PhaseEvents);
        run_phase(55, 0, PhaseEvents);
        run_phase(0, 55, PhaseEvents);
        run_phase(31, 31, PhaseEvents);

        repeat (20) @(posedge clk);
        $display("Drove %0d events: %0d received bytes, %0d host reads, %0d transmit bytes,",
                 events_sent, kind_count[REQ_RX_BYTE], kind_count[REQ_HOST_READ],
                 kind_count[REQ_TX_BYTE]);
        $display("%0d transmitter ready, %0d overflow queries; %0d result beats checked.",
                 kind_count[REQ_TX_READY], kind_count[REQ_OVF_QUERY], checked);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* sim.f */
design/urtb_pkg.sv
design/urtb_ram.sv
design/urtb_ctrl.sv
design/urtb_dp.sv
design/uart_rx_tx_ring_buffers.sv
design/urtb_chk.sv
dv/urtb_ring_checker.sv
dv/tb.sv
